### hdl/rrps_pkg.sv
package rrps_pkg;

    localparam int MAX_PROCS = 64;
    localparam int RING_AW   = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int ID_W      = 6;
    localparam int ID_SLOTS  = 64;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 32;
    localparam int QUANTUM_W = 8;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd7;
    localparam logic [QUANTUM_W-1:0] SLICE_MAX     = 8'hFF;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef struct packed {
        logic [BURST_W-1:0] rem;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  stamp;
    } proc_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_TABLE,
        ST_RESULT
    } state_t;

endpackage

### hdl/rrps_ram.sv
module rrps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/round_robin_process_scheduler_unit.sv
// Round-robin process scheduler. An arrival (s_func = 0) enqueues s_proc_id with
// s_burst_len service units, stamped with the current time; it is dropped if the
// id is still active, the burst is zero or the ready ring has no free slot, and
// it gives no result. A tick (s_func = 1) first puts back the process preempted
// on the previous tick, advances time by one and runs the head process for one
// unit, giving one result; a tick with nothing queued only advances time.
// An arrival and an idle tick are handled in the idle state; a tick that runs a
// process then steps through ring read, dependent process table read, write-back
// and result stage, set by the two chained memory reads. The result stage holds
// while the output register is still occupied. The quantum (cfg_wdata) may only
// be written while the block is idle; a quantum of 0 behaves as 1.
module round_robin_process_scheduler_unit (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrps_pkg::QUANTUM_W-1:0] cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [rrps_pkg::ID_W-1:0]     s_proc_id,
    input  logic [rrps_pkg::BURST_W-1:0]  s_burst_len,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rrps_pkg::ID_W-1:0]     m_ran_id,
    output logic [rrps_pkg::TIME_W-1:0]   m_now_time,
    output logic                          m_finished,
    output logic [rrps_pkg::TIME_W-1:0]   m_turnaround,
    output logic [rrps_pkg::TIME_W-1:0]   m_waiting
);

    import rrps_pkg::*;

    state_t state_reg, state_next;

    logic [QUANTUM_W-1:0] quantum_reg;
    logic [RING_AW-1:0]   head_reg, head_next;
    logic [RING_AW-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [QUANTUM_W-1:0] slice_reg, slice_next;
    logic                 pend_reg, pend_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic [ID_SLOTS-1:0]  active_reg, active_next;
    logic                 fwd_reg, fwd_next;

    logic [ID_W-1:0]      node_reg, node_next;
    logic                 done_reg, done_next;
    logic [TIME_W-1:0]    turn_reg, turn_next;
    logic [BURST_W-1:0]   burst_reg, burst_next;

    logic                 m_valid_reg, m_valid_next;
    logic [ID_W-1:0]      m_ran_id_reg, m_ran_id_next;
    logic [TIME_W-1:0]    m_now_time_reg, m_now_time_next;
    logic                 m_finished_reg, m_finished_next;
    logic [TIME_W-1:0]    m_turnaround_reg, m_turnaround_next;
    logic [TIME_W-1:0]    m_waiting_reg, m_waiting_next;

    logic                 in_fire;
    logic                 out_free;
    logic                 arrival_ok;
    logic                 ring_we;
    logic [ID_W-1:0]      ring_wdata;
    logic [ID_W-1:0]      ring_rdata;
    logic                 tbl_we;
    logic [ID_W-1:0]      tbl_waddr;
    proc_entry_t          tbl_wdata;
    proc_entry_t          tbl_rdata;
    logic [ID_W-1:0]      head_id;
    logic [BURST_W-1:0]   rem_dec;
    logic [QUANTUM_W-1:0] slice_inc;
    logic [QUANTUM_W-1:0] q_eff;

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] pos);
        ring_inc = (pos == RING_AW'(MAX_PROCS - 1)) ? '0 : pos + 1'b1;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid & s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // a pending put-back holds a slot in reserve
    assign arrival_ok = (s_burst_len != '0) && !active_reg[s_proc_id]
                        && (({1'b0, count_reg} + (CNT_W + 1)'(pend_reg))
                            < (CNT_W + 1)'(MAX_PROCS));

    // ring was empty when the put-back went in: head is that id, not the stale read
    assign head_id   = fwd_reg ? pend_id_reg : ring_rdata;
    assign rem_dec   = tbl_rdata.rem - 1'b1;
    assign slice_inc = (slice_reg == SLICE_MAX) ? slice_reg : slice_reg + 1'b1;
    assign q_eff     = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;

    rrps_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_PROCS)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    rrps_ram #(
        .WIDTH ($bits(proc_entry_t)),
        .DEPTH (ID_SLOTS)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (head_id),
        .rdata (tbl_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_func == FUNC_TICK && (count_reg != '0 || pend_reg)) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:   state_next = ST_TABLE;
            ST_TABLE:  state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready           = (state_reg == ST_IDLE);
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        time_next         = time_reg;
        slice_next        = slice_reg;
        pend_next         = pend_reg;
        pend_id_next      = pend_id_reg;
        active_next       = active_reg;
        fwd_next          = fwd_reg;
        node_next         = node_reg;
        done_next         = done_reg;
        turn_next         = turn_reg;
        burst_next        = burst_reg;
        ring_we           = 1'b0;
        ring_wdata        = s_proc_id;
        tbl_we            = 1'b0;
        tbl_waddr         = s_proc_id;
        tbl_wdata.rem     = s_burst_len;
        tbl_wdata.burst   = s_burst_len;
        tbl_wdata.stamp   = time_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_ran_id_next     = m_ran_id_reg;
        m_now_time_next   = m_now_time_reg;
        m_finished_next   = m_finished_reg;
        m_turnaround_next = m_turnaround_reg;
        m_waiting_next    = m_waiting_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_func == FUNC_ARRIVAL) begin
                        if (arrival_ok) begin
                            ring_we                = 1'b1;
                            tbl_we                 = 1'b1;
                            active_next[s_proc_id] = 1'b1;
                            tail_next              = ring_inc(tail_reg);
                            count_next             = count_reg + 1'b1;
                        end
                    end else begin
                        time_next = time_reg + 1'b1;
                        fwd_next  = pend_reg && (count_reg == '0);
                        if (pend_reg) begin
                            ring_we    = 1'b1;
                            ring_wdata = pend_id_reg;
                            tail_next  = ring_inc(tail_reg);
                            count_next = count_reg + 1'b1;
                            pend_next  = 1'b0;
                        end
                    end
                end
            end
            ST_HEAD: begin
                node_next = head_id;
            end
            ST_TABLE: begin
                tbl_we          = 1'b1;
                tbl_waddr       = node_reg;
                tbl_wdata.rem   = rem_dec;
                tbl_wdata.burst = tbl_rdata.burst;
                tbl_wdata.stamp = tbl_rdata.stamp;
                done_next       = (rem_dec == '0);
                turn_next       = time_reg - tbl_rdata.stamp;
                burst_next      = tbl_rdata.burst;
                if (rem_dec == '0) begin
                    active_next[node_reg] = 1'b0;
                    slice_next            = '0;
                    head_next             = ring_inc(head_reg);
                    count_next            = count_reg - 1'b1;
                end else if (slice_inc >= q_eff) begin
                    slice_next   = '0;
                    head_next    = ring_inc(head_reg);
                    count_next   = count_reg - 1'b1;
                    pend_next    = 1'b1;
                    pend_id_next = node_reg;
                end else begin
                    slice_next = slice_inc;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_ran_id_next     = node_reg;
                    m_now_time_next   = time_reg;
                    m_finished_next   = done_reg;
                    m_turnaround_next = done_reg ? turn_reg : '0;
                    m_waiting_next    = done_reg ? (turn_reg - TIME_W'(burst_reg)) : '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            quantum_reg <= QUANTUM_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            time_reg    <= '0;
            slice_reg   <= '0;
            pend_reg    <= 1'b0;
            pend_id_reg <= '0;
            active_reg  <= '0;
            fwd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_valid && cfg_ready) begin
                quantum_reg <= cfg_wdata;
            end
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            slice_reg   <= slice_next;
            pend_reg    <= pend_next;
            pend_id_reg <= pend_id_next;
            active_reg  <= active_next;
            fwd_reg     <= fwd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg         <= node_next;
        done_reg         <= done_next;
        turn_reg         <= turn_next;
        burst_reg        <= burst_next;
        m_ran_id_reg     <= m_ran_id_next;
        m_now_time_reg   <= m_now_time_next;
        m_finished_reg   <= m_finished_next;
        m_turnaround_reg <= m_turnaround_next;
        m_waiting_reg    <= m_waiting_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_ran_id     = m_ran_id_reg;
    assign m_now_time   = m_now_time_reg;
    assign m_finished   = m_finished_reg;
    assign m_turnaround = m_turnaround_reg;
    assign m_waiting    = m_waiting_reg;

endmodule

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rrps_pkg::*;

    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 200;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic [ID_W-1:0]   ran_id;
        logic [TIME_W-1:0] now_time;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } run_t;

    // tracks scheduler state and the runs the block still owes us
    class rr_tracker;
        logic [QUANTUM_W-1:0] quantum;
        logic [ID_W-1:0]      ready_ring [MAX_PROCS];
        int unsigned          ring_head;
        int unsigned          ring_tail;
        int unsigned          ring_count;
        logic [BURST_W-1:0]   units_left [ID_SLOTS];
        logic [BURST_W-1:0]   burst_orig [ID_SLOTS];
        logic [TIME_W-1:0]    arrived_at [ID_SLOTS];
        logic [TIME_W-1:0]    clock_now;
        logic [7:0]           slice_used;
        bit                   requeue_pending;
        logic [ID_W-1:0]      requeue_id;
        run_t                 expected_runs [$];
        int unsigned          mismatches;

        function new();
            quantum = QUANTUM_RESET;
            ring_head = 0;
            ring_tail = 0;
            ring_count = 0;
            foreach (ready_ring[i]) ready_ring[i] = '0;
            foreach (units_left[i]) begin
                units_left[i] = '0;
                burst_orig[i] = '0;
                arrived_at[i] = '0;
            end
            clock_now = '0;
            slice_used = '0;
            requeue_pending = 1'b0;
            requeue_id = '0;
            mismatches = 0;
        endfunction

        function void ring_push(logic [ID_W-1:0] id);
            if (ring_count >= MAX_PROCS) return;
            ready_ring[ring_tail] = id;
            ring_tail = (ring_tail + 1) % MAX_PROCS;
            ring_count++;
        endfunction

        function void ring_pop();
            if (ring_count == 0) return;
            ring_head = (ring_head + 1) % MAX_PROCS;
            ring_count--;
        endfunction

        // returns 1 when the item changes state (ignored arrivals return 0)
        function bit apply_item(logic func, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
            logic [ID_W-1:0]      node;
            logic [QUANTUM_W-1:0] q;
            run_t                 r;
            if (func == FUNC_ARRIVAL) begin
                if (burst == '0 || units_left[id] != '0) return 1'b0;
                if (ring_count + (requeue_pending ? 1 : 0) >= MAX_PROCS) return 1'b0;
                units_left[id] = burst;
                burst_orig[id] = burst;
                arrived_at[id] = clock_now;
                ring_push(id);
                return 1'b1;
            end
            // put-back lands after arrivals seen since the preempting tick
            if (requeue_pending) begin
                ring_push(requeue_id);
                requeue_pending = 1'b0;
            end
            clock_now = clock_now + 1;
            if (ring_count == 0) return 1'b1;
            node = ready_ring[ring_head];
            if (slice_used != 8'hFF) slice_used++;
            units_left[node] = units_left[node] - 1'b1;
            q = (quantum == '0) ? 8'd1 : quantum;
            r.ran_id = node;
            r.now_time = clock_now;
            r.finished = 1'b0;
            r.turnaround = '0;
            r.waiting = '0;
            if (units_left[node] == '0) begin
                r.finished = 1'b1;
                r.turnaround = clock_now - arrived_at[node];
                r.waiting = r.turnaround - {16'd0, burst_orig[node]};
                slice_used = '0;
                ring_pop();
            end else if (slice_used >= q) begin
                slice_used = '0;
                ring_pop();
                requeue_pending = 1'b1;
                requeue_id = node;
            end
            expected_runs.push_back(r);
            return 1'b1;
        endfunction

        task report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
            if (mismatches < MAX_REPORTS)
                $display("mismatch %s: got %0h, expected %0h", what, got, want);
            mismatches++;
        endtask

        task check_run(run_t got);
            run_t want;
            if (expected_runs.size() == 0) begin
                report_mismatch("result with nothing pending, ran_id",
                                TIME_W'(got.ran_id), '0);
                return;
            end
            want = expected_runs.pop_front();
            if (got.ran_id !== want.ran_id)
                report_mismatch("ran_id", TIME_W'(got.ran_id), TIME_W'(want.ran_id));
            if (got.now_time !== want.now_time)
                report_mismatch("now_time", got.now_time, want.now_time);
            if (got.finished !== want.finished)
                report_mismatch("finished", TIME_W'(got.finished), TIME_W'(want.finished));
            if (got.turnaround !== want.turnaround)
                report_mismatch("turnaround", got.turnaround, want.turnaround);
            if (got.waiting !== want.waiting)
                report_mismatch("waiting", got.waiting, want.waiting);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [QUANTUM_W-1:0] cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_func = FUNC_ARRIVAL;
    logic [ID_W-1:0]      s_proc_id = '0;
    logic [BURST_W-1:0]   s_burst_len = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ID_W-1:0]      m_ran_id;
    logic [TIME_W-1:0]    m_now_time;
    logic                 m_finished;
    logic [TIME_W-1:0]    m_turnaround;
    logic [TIME_W-1:0]    m_waiting;

    rr_tracker tracker;
    int        burst_left = 0;
    bit        gaps_on = 1'b1;
    int        hold_req = 0;
    int        cycle_count = 0;

    round_robin_process_scheduler_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_proc_id    (s_proc_id),
        .s_burst_len  (s_burst_len),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ran_id     (m_ran_id),
        .m_now_time   (m_now_time),
        .m_finished   (m_finished),
        .m_turnaround (m_turnaround),
        .m_waiting    (m_waiting)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[round_robin_process_scheduler_unit] ERROR");
            $finish;
        end
    end

    // results are checked before the input of the same edge is applied
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_run({m_ran_id, m_now_time, m_finished, m_turnaround, m_waiting});
            if (cfg_valid && cfg_ready)
                tracker.quantum = cfg_wdata;
            if (s_valid && s_ready)
                void'(tracker.apply_item(s_func, s_proc_id, s_burst_len));
        end
    end

    // receiver: changing stall modes, plus a long hold on request
    initial begin
        int hold_served;
        int mode;
        int mode_left;
        hold_served = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_served) begin
                hold_served = hold_req;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (mode_left % 4) != 0;
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(logic func, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_func <= func;
        s_proc_id <= id;
        s_burst_len <= burst;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (tracker.expected_runs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_quantum(logic [QUANTUM_W-1:0] q);
        cfg_valid <= 1'b1;
        cfg_wdata <= q;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [QUANTUM_W-1:0] quanta [7];
        int                   id_order [64];
        int                   pick;
        int                   swap_at;
        int                   tmp;
        logic [ID_W-1:0]      id;
        logic [BURST_W-1:0]   burst;

        tracker = new();
        quanta = '{8'd3, 8'd255, 8'd2, 8'd0, 8'd1, 8'd15, QUANTUM_RESET};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle tick, zero burst, widest burst, duplicates, finish at quantum end,
        // put-back ordered after a fresh arrival
        send_item(FUNC_TICK, 6'd0, 16'd0);
        send_item(FUNC_ARRIVAL, 6'd0, 16'd0);
        send_item(FUNC_ARRIVAL, 6'd63, 16'hFFFF);
        send_item(FUNC_ARRIVAL, 6'd1, 16'd1);
        send_item(FUNC_ARRIVAL, 6'd1, 16'd5);
        send_item(FUNC_ARRIVAL, 6'd42, 16'd7);
        repeat (7) send_item(FUNC_TICK, 6'd63, 16'hFFFF);
        send_item(FUNC_ARRIVAL, 6'd63, 16'd1);
        send_item(FUNC_ARRIVAL, 6'd5, 16'd2);
        repeat (11) send_item(FUNC_TICK, 6'd0, 16'd0);

        foreach (quanta[p]) begin
            settle_idle();
            write_quantum(quanta[p]);
            gaps_on = (p % 2) == 0;
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                id = 6'($urandom_range(0, 63));
                if (pick < 55) begin
                    send_item(FUNC_TICK, 6'($urandom), 16'($urandom));
                end else if (pick < 92) begin
                    burst = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 8))
                                                       : 16'($urandom_range(9, 60));
                    send_item(FUNC_ARRIVAL, id, burst);
                end else if (pick < 96 && tracker.units_left[id] != '0) begin
                    // duplicate of a live id with an arbitrary burst
                    send_item(FUNC_ARRIVAL, id, 16'($urandom));
                end else begin
                    send_item(FUNC_ARRIVAL, id, 16'd0);
                end
            end
        end

        // fill every slot, poke the full ring, then starve the output
        settle_idle();
        write_quantum(8'd4);
        gaps_on = 1'b1;
        foreach (id_order[i]) id_order[i] = i;
        for (int i = 63; i > 0; i--) begin
            swap_at = $urandom_range(0, i);
            tmp = id_order[i];
            id_order[i] = id_order[swap_at];
            id_order[swap_at] = tmp;
        end
        foreach (id_order[i]) send_item(FUNC_ARRIVAL, 6'(id_order[i]), 16'($urandom_range(1, 6)));
        repeat (5) send_item(FUNC_ARRIVAL, 6'($urandom), 16'($urandom_range(1, 6)));
        hold_req <= hold_req + 1;
        repeat (80) send_item(FUNC_TICK, 6'($urandom), 16'($urandom));

        settle_idle();
        if (tracker.mismatches == 0)
            $display("[round_robin_process_scheduler_unit] OK");
        else
            $display("[round_robin_process_scheduler_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/rrps_pkg.sv
hdl/rrps_ram.sv
hdl/round_robin_process_scheduler_unit.sv
bench/tb_top.sv
